// ----- hw/rtl/tfcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfcm_pkg: shared types and constants of the thermal false color mapper
// Frame geometry, field widths, command codes and the divider interface.
// ----------------------------------------------------------------------------
package tfcm_pkg;

    // frame geometry
    localparam int ROWS    = 16;
    localparam int COLS    = 12;
    localparam int PIXELS  = ROWS * COLS;
    localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // transaction fields
    localparam int CMD_W   = 1;
    localparam int IDX_W   = 8;
    localparam int TEMP_W  = 16;
    localparam int COLOR_W = 24;
    localparam int LEVEL_W = 9;

    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

    // level quantization
    localparam int NLEVELS   = 383;
    localparam int TOP_LEVEL = NLEVELS - 1;

    // datapath widths: offset/span fit TEMP_W unsigned, 383*d fits PROD_W
    localparam int PROD_W = TEMP_W + 9;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DEN_W  = TEMP_W + 1;
    localparam int QUO_W  = LEVEL_W;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int DVS_W  = DEN_W + QUO_W - 1;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// ----- hw/rtl/tfcm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfcm_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tfcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hw/rtl/tfcm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfcm_div: iterative restoring divider
// One compare-subtract per cycle, QUO_W quotient bits, MSB first.
// Caller guarantees num < den * 2**QUO_W.
// ----------------------------------------------------------------------------
module tfcm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tfcm_pkg::t_div_req i_req,
    output tfcm_pkg::t_div_rsp     o_rsp
);
    import tfcm_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [QUO_W-1:0] r_quo;

    logic             n_ge;
    logic [NUM_W-1:0] n_diff;

    // the shared compare/subtract
    always_comb begin
        n_diff = r_rem - NUM_W'(r_dvs);
        n_ge   = (r_rem >= NUM_W'(r_dvs));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dvs <= {i_req.den, {(QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            if (n_ge) begin
                r_rem <= n_diff;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[QUO_W-2:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// ----- hw/rtl/thermal_false_color_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermal_false_color_mapper: thermal frame to false color level and RGB
// Frame store with running min/max, nearest-level quantizer, color ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries command, pixel_index and
//   temperature. A load transaction (command 0) writes the pixel into the
//   frame store and widens the running min/max; pixel 0 restarts them. It
//   completes in the accept cycle and the block stays ready. Loads or reads
//   at an index past the frame are dropped with no result.
//   A read transaction (command 1) yields one result on the output channel
//   (o_valid / i_stall): the level 0..382 and its packed 24-bit color.
//   A read goes from S_READ straight to S_DONE when the level is fixed by
//   range checks (flat frame, pixel at or beyond min/max), through S_MUL
//   and S_SETUP when the scaled offset already reaches the top level, and
//   on through S_DIV when it needs the 9-bit serial divide; the divider
//   retires one quotient bit per cycle. The input is stalled for the whole
//   read, so reads do not overlap. The result sits in an output register:
//   while the receiver stalls it, the block still takes the next
//   transaction and holds a finished read until the register frees.
//   Reset clears min/max to zero and empties the pipeline; the frame store
//   is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module thermal_false_color_mapper (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [tfcm_pkg::CMD_W-1:0]    i_command,
    input  wire logic [tfcm_pkg::IDX_W-1:0]    i_pixel_index,
    input  wire logic [tfcm_pkg::TEMP_W-1:0]   i_temperature,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [tfcm_pkg::COLOR_W-1:0]  o_color,
    output logic      [tfcm_pkg::LEVEL_W-1:0]  o_level
);
    import tfcm_pkg::*;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_SETUP = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    // k = 382 - level, four linear segments of the red-yellow-cyan-blue ramp
    function automatic logic [COLOR_W-1:0] ramp_color(input logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W-1:0] k;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        k = LEVEL_W'(TOP_LEVEL) - lvl;
        if (k <= LEVEL_W'(127)) begin
            r = 8'(LEVEL_W'(255) - k);
            g = 8'({k[7:0], 1'b0});
            b = 8'd0;
        end else if (k <= LEVEL_W'(254)) begin
            r = 8'(LEVEL_W'(255) - k);
            g = 8'd254;
            b = 8'({k - LEVEL_W'(127), 1'b0});
        end else if (k == LEVEL_W'(255)) begin
            r = 8'd0;
            g = 8'd254;
            b = 8'd255;
        end else begin
            r = 8'(k - LEVEL_W'(255));
            g = 8'(9'd254 - 9'({k - LEVEL_W'(255), 1'b0}));
            b = 8'd255;
        end
        return {r, g, b};
    endfunction

    t_state               r_state;
    t_state               n_state;

    logic signed [TEMP_W-1:0] r_min;
    logic signed [TEMP_W-1:0] r_max;

    logic [TEMP_W-1:0]    r_d;      // pixel offset above min
    logic [TEMP_W-1:0]    r_sp;     // max - min
    logic [PROD_W-1:0]    r_s;      // 383 * d
    logic [PROD_W-1:0]    r_top;    // 382 * span
    logic [LEVEL_W-1:0]   r_level;

    logic                 r_out_valid;
    logic [COLOR_W-1:0]   r_color;
    logic [LEVEL_W-1:0]   r_out_level;

    logic                 n_accept;
    logic                 n_in_range;
    logic                 n_we;
    logic                 n_re;
    logic [TEMP_W-1:0]    n_rdata;
    logic signed [TEMP_W:0] n_span;
    logic signed [TEMP_W:0] n_off;
    logic                 n_out_free;

    t_div_req             n_div_req;
    t_div_rsp             n_div_rsp;

    assign n_accept   = i_valid && !o_stall;
    assign n_in_range = (int'(i_pixel_index) < PIXELS);
    assign n_we       = n_accept && n_in_range && (i_command == CMD_LOAD);
    assign n_re       = n_accept && n_in_range && (i_command == CMD_READ);
    assign n_out_free = !r_out_valid || !i_stall;

    tfcm_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_re    (n_re),
        .i_addr  (ADDR_W'(i_pixel_index)),
        .i_wdata (i_temperature),
        .o_rdata (n_rdata)
    );

    // span is never negative: min/max start equal and only widen
    assign n_span = {r_max[TEMP_W-1], r_max} - {r_min[TEMP_W-1], r_min};
    assign n_off  = {n_rdata[TEMP_W-1], n_rdata} - {r_min[TEMP_W-1], r_min};

    // divide (2s + span) / (2 span) gives the nearest level, ties upward
    assign n_div_req.start = (r_state == S_SETUP) && (r_s < r_top);
    assign n_div_req.num   = NUM_W'({r_s, 1'b0}) + NUM_W'(r_sp);
    assign n_div_req.den   = {r_sp, 1'b0};

    tfcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (n_re) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (n_span <= 0 || n_off <= 0 || n_off >= n_span) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = (r_s < r_top) ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (n_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (n_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // running frame extremes; pixel 0 restarts them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (n_we) begin
            if (i_pixel_index == '0) begin
                r_min <= $signed(i_temperature);
                r_max <= $signed(i_temperature);
            end else begin
                if ($signed(i_temperature) < r_min) begin
                    r_min <= $signed(i_temperature);
                end
                if ($signed(i_temperature) > r_max) begin
                    r_max <= $signed(i_temperature);
                end
            end
        end
    end

    // level datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_READ: begin
                r_d  <= n_off[TEMP_W-1:0];
                r_sp <= n_span[TEMP_W-1:0];
                if (n_span <= 0 || n_off >= n_span) begin
                    r_level <= LEVEL_W'(TOP_LEVEL);
                end else begin
                    r_level <= '0;
                end
            end
            S_MUL: begin
                // 383 = 512 - 128 - 1, 382 = 512 - 128 - 2
                r_s   <= PROD_W'({r_d, 9'b0}) - PROD_W'({r_d, 7'b0}) - PROD_W'(r_d);
                r_top <= PROD_W'({r_sp, 9'b0}) - PROD_W'({r_sp, 7'b0})
                         - PROD_W'({r_sp, 1'b0});
            end
            S_SETUP: begin
                r_level <= LEVEL_W'(TOP_LEVEL);
            end
            S_DIV: begin
                if (n_div_rsp.done) begin
                    if (n_div_rsp.quo >= QUO_W'(TOP_LEVEL)) begin
                        r_level <= LEVEL_W'(TOP_LEVEL - 1);
                    end else begin
                        r_level <= n_div_rsp.quo;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && n_out_free) begin
            r_color     <= ramp_color(r_level);
            r_out_level <= r_level;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_color = r_color;
    assign o_level = r_out_level;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the thermal false color mapper
// Loads thermal frames, reads pixels back and checks each level and packed
// color against a cycle-free predictor, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import tfcm_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS   = 500;
    localparam int DIRECTED_ROWS  = 26;
    localparam int IDLE_PERCENT   = 28;
    localparam int HOLD_CYCLES    = 80;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 24;   // covers the divide path
    localparam int HOLD_AT_ITEM   = 150;
    localparam int PAUSE_AT_ITEM  = 350;
    localparam int STEADY_FIRST   = 400;  // no idling on either side from here
    localparam int STEADY_LAST    = 480;  // ... up to here

    localparam logic [COLOR_W-1:0] COLOR_HOT  = 24'hFF0000;  // level 382
    localparam logic [COLOR_W-1:0] COLOR_COLD = 24'h7F00FF;  // level 0
    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = LEVEL_W'(TOP_LEVEL);
    localparam logic [LEVEL_W-1:0] LEVEL_BOT  = '0;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [LEVEL_W-1:0] level;
    } t_color_result;

    // one directed transaction; expected result is typed in only when typed=1
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [TEMP_W-1:0]  temp;
        logic               typed;
        logic [COLOR_W-1:0] color;
        logic [LEVEL_W-1:0] level;
    } t_stim_row;

    typedef enum int {TEMP_FULL, TEMP_NARROW, TEMP_EXTREME} t_temp_mode;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_command     = CMD_LOAD;
    logic [IDX_W-1:0]   i_pixel_index = '0;
    logic [TEMP_W-1:0]  i_temperature = '0;
    logic               o_valid;
    logic               i_stall       = 1'b1;
    logic [COLOR_W-1:0] o_color;
    logic [LEVEL_W-1:0] o_level;

    thermal_false_color_mapper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_pixel_index (i_pixel_index),
        .i_temperature (i_temperature),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_color       (o_color),
        .o_level       (o_level)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the frame store and the running range
    // ------------------------------------------------------------------------
    logic signed [TEMP_W-1:0] frame_temp [PIXELS];
    bit                       pixel_written [PIXELS];
    logic signed [TEMP_W-1:0] frame_lo = '0;
    logic signed [TEMP_W-1:0] frame_hi = '0;

    t_color_result expected_colors [$];
    int            mismatch_count = 0;

    // control shared between the sender and the receiver process
    logic rx_armed     = 1'b0;
    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;

    // random frame shape
    t_temp_mode temp_mode   = TEMP_FULL;
    int         temp_base   = 0;
    int         temp_spread = 1;

    // Nearest of 383 levels. Level i sits at lo + i*span/383; level 382 holds all up to hi.
    // Compared exactly: 383*d against i*span, ties rounding up.
    function automatic logic [LEVEL_W-1:0] quantize_level(logic signed [TEMP_W-1:0] t);
        int     span;
        int     off;
        longint scaled;
        longint sp;
        longint q;
        span = int'(frame_hi) - int'(frame_lo);
        off  = int'(t) - int'(frame_lo);
        if (span <= 0) return LEVEL_TOP;     // flat frame: all levels coincide
        if (off <= 0) return LEVEL_BOT;      // at or below the minimum
        if (off >= span) return LEVEL_TOP;   // at or above the maximum
        sp     = span;
        scaled = longint'(NLEVELS) * off;
        if (scaled >= longint'(TOP_LEVEL) * sp) return LEVEL_TOP;
        q = (2 * scaled + sp) / (2 * sp);
        // rounding up into the top slot is not allowed below 382*span
        if (q > TOP_LEVEL - 1) q = TOP_LEVEL - 1;
        return LEVEL_W'(q);
    endfunction

    // red -> yellow -> cyan -> blue, indexed from the hot end
    function automatic logic [COLOR_W-1:0] ramp_rgb(logic [LEVEL_W-1:0] level);
        int k;
        int r;
        int g;
        int b;
        k = TOP_LEVEL - int'(level);
        if (k <= 127) begin
            r = 255 - k;
            g = 2 * k;
            b = 0;
        end else if (k <= 254) begin
            r = 255 - k;
            g = 254;
            b = 2 * (k - 127);
        end else if (k == 255) begin
            r = 0;
            g = 254;
            b = 255;
        end else begin
            r = k - 255;
            g = 254 - 2 * (k - 255);
            b = 255;
        end
        return {8'(r), 8'(g), 8'(b)};
    endfunction

    // Apply one accepted transaction to the predictor; reads queue a result.
    task automatic track_transaction(input logic [CMD_W-1:0] cmd,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [TEMP_W-1:0] temp);
        logic signed [TEMP_W-1:0] t;
        logic [LEVEL_W-1:0]       lvl;
        t = temp;
        if (idx >= PIXELS) return;   // past the frame: dropped, no result
        if (cmd == CMD_LOAD) begin
            frame_temp[idx]    = t;
            pixel_written[idx] = 1'b1;
            if (idx == 0) begin
                frame_lo = t;
                frame_hi = t;
            end else begin
                if (t < frame_lo) frame_lo = t;
                if (t > frame_hi) frame_hi = t;
            end
        end else begin
            lvl = quantize_level(frame_temp[idx]);
            expected_colors.push_back('{color: ramp_rgb(lvl), level: lvl});
        end
    endtask

    // Offer one transaction; returns at the edge that accepts it.
    task automatic offer_transaction(input logic [CMD_W-1:0] cmd,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [TEMP_W-1:0] temp);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_pixel_index <= idx;
        i_temperature <= temp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // Sender stops and waits for every queued result, then for the slow path.
    task automatic wait_results_drained;
        i_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Temperature for the next in-order frame load, per the frame's mode.
    function automatic logic [TEMP_W-1:0] frame_temperature;
        int v;
        case (temp_mode)
            TEMP_FULL: v = int'($urandom_range(0, 65535)) - 32768;
            TEMP_NARROW: begin
                v = temp_base + int'($urandom_range(0, temp_spread));
                if (v > 32767) v = 32767;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = temp_base;
                    default: v = int'($urandom_range(0, 65535)) - 32768;
                endcase
            end
        endcase
        return TEMP_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Directed transactions. Typed-in results only where they are obvious:
    // flat frames, pixels at or past the range ends.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // right after reset the range is 0..0, a non-zero index keeps it flat
        '{CMD_LOAD, 8'd5,   16'h0000, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd5,   16'h0000, 1'b1, COLOR_HOT,  LEVEL_TOP},
        // pixel 0 restarts the range
        '{CMD_LOAD, 8'd0,   16'h0064, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd0,   16'h0000, 1'b1, COLOR_HOT,  LEVEL_TOP},
        // full-scale extremes
        '{CMD_LOAD, 8'd1,   16'h8000, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_LOAD, 8'd2,   16'h7FFF, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd1,   16'h0000, 1'b1, COLOR_COLD, LEVEL_BOT},
        '{CMD_READ, 8'd2,   16'h0000, 1'b1, COLOR_HOT,  LEVEL_TOP},
        '{CMD_READ, 8'd0,   16'hFFFF, 1'b0, 24'h0,      LEVEL_BOT},
        // past the frame: loads leave the range alone, reads give nothing
        '{CMD_LOAD, 8'd192, 16'h1234, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_LOAD, 8'd255, 16'hFFFF, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd200, 16'h0000, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd255, 16'h0000, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd2,   16'h0000, 1'b1, COLOR_HOT,  LEVEL_TOP},
        // new frame 0..766: span of 766 puts pixel 4 exactly between levels
        '{CMD_LOAD, 8'd0,   16'h0000, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_LOAD, 8'd3,   16'h02FE, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_LOAD, 8'd4,   16'h0001, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd4,   16'h0000, 1'b0, 24'h0,      LEVEL_BOT},
        // old-frame pixels outside the new range, then the new range ends
        '{CMD_READ, 8'd1,   16'h0000, 1'b1, COLOR_COLD, LEVEL_BOT},
        '{CMD_READ, 8'd2,   16'h0000, 1'b1, COLOR_HOT,  LEVEL_TOP},
        '{CMD_READ, 8'd3,   16'h0000, 1'b1, COLOR_HOT,  LEVEL_TOP},
        '{CMD_READ, 8'd0,   16'h0000, 1'b1, COLOR_COLD, LEVEL_BOT},
        // 763 rounds up to 382 but lies below the top: held at 381
        '{CMD_LOAD, 8'd6,   16'h02FB, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd6,   16'h0000, 1'b0, 24'h0,      LEVEL_BOT},
        // last pixel of the frame, at the exact midpoint of the range
        '{CMD_LOAD, 8'd191, 16'h017F, 1'b0, 24'h0,      LEVEL_BOT},
        '{CMD_READ, 8'd191, 16'h0000, 1'b0, 24'h0,      LEVEL_BOT}
    };

    // ------------------------------------------------------------------------
    // Receiver: checks each accepted result, then picks next cycle's stall.
    // Inputs and outputs are sampled right at the edge, before any update.
    // ------------------------------------------------------------------------
    t_color_result due;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (rx_armed) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual color %06h level %0d",
                             $time, o_color, o_level);
                    mismatch_count++;
                end else begin
                    due = expected_colors.pop_front();
                    if (o_color !== due.color) begin
                        $display("%0t: color mismatch, expected %06h, actual %06h",
                                 $time, due.color, o_color);
                        mismatch_count++;
                    end
                    if (o_level !== due.level) begin
                        $display("%0t: level mismatch, expected %0d, actual %0d",
                                 $time, due.level, o_level);
                        mismatch_count++;
                    end
                end
            end
            // long hold-off once, counted here; the sender keeps offering
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else if (no_idle) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, then random frames
    // ------------------------------------------------------------------------
    initial begin
        int                mapped_items;
        int                pick;
        int                fill_ptr;
        int                frame_len;
        bit                paused;
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [TEMP_W-1:0] temp;

        mapped_items = 0;
        fill_ptr     = 0;
        frame_len    = 12;
        paused       = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rx_armed <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            offer_transaction(directed_rows[n].cmd, directed_rows[n].idx,
                              directed_rows[n].temp);
            if (directed_rows[n].typed)
                expected_colors.push_back('{color: directed_rows[n].color,
                                            level: directed_rows[n].level});
            else
                track_transaction(directed_rows[n].cmd, directed_rows[n].idx,
                                  directed_rows[n].temp);
        end

        while (mapped_items < RANDOM_ITEMS) begin
            if (mapped_items == HOLD_AT_ITEM) hold_request <= 1'b1;
            if (mapped_items == PAUSE_AT_ITEM && !paused) begin
                paused = 1'b1;
                wait_results_drained();
            end
            no_idle <= (mapped_items >= STEADY_FIRST && mapped_items < STEADY_LAST);

            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                // noise past the frame, ignored by the block
                cmd  = CMD_W'($urandom_range(0, 1));
                idx  = IDX_W'($urandom_range(PIXELS, 255));
                temp = TEMP_W'($urandom);
            end else if (pick < 42) begin
                // in-order frame fill; pixel 0 opens a new frame shape
                if (fill_ptr == 0) begin
                    temp_mode = t_temp_mode'($urandom_range(0, 2));
                    temp_base = int'($urandom_range(0, 65535)) - 32768;
                    case ($urandom_range(0, 5))
                        0:       temp_spread = 1;
                        1:       temp_spread = 2;
                        2:       temp_spread = 7;
                        3:       temp_spread = 766;
                        4:       temp_spread = 3000;
                        default: temp_spread = 20000;
                    endcase
                    frame_len = ($urandom_range(0, 3) == 0) ? PIXELS
                                                           : $urandom_range(2, 24);
                end
                cmd      = CMD_LOAD;
                idx      = IDX_W'(fill_ptr);
                temp     = frame_temperature();
                fill_ptr = (fill_ptr + 1 == frame_len) ? 0 : fill_ptr + 1;
            end else if (pick < 48) begin
                // out-of-order load, widens the range mid-frame
                cmd  = CMD_LOAD;
                idx  = IDX_W'($urandom_range(1, PIXELS - 1));
                temp = frame_temperature();
            end else begin
                // read back a written pixel, mostly from the current frame
                cmd  = CMD_READ;
                temp = TEMP_W'($urandom);
                if ($urandom_range(0, 9) < 7) begin
                    do idx = IDX_W'($urandom_range(0, frame_len - 1));
                    while (!pixel_written[idx]);
                end else begin
                    do idx = IDX_W'($urandom_range(0, PIXELS - 1));
                    while (!pixel_written[idx]);
                end
            end

            offer_transaction(cmd, idx, temp);
            track_transaction(cmd, idx, temp);
            if (idx < PIXELS) mapped_items++;
        end

        wait_results_drained();

        if (mismatch_count == 0 && expected_colors.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- thermal_false_color_mapper.f -----
hw/rtl/tfcm_pkg.sv
hw/rtl/tfcm_ram.sv
hw/rtl/tfcm_div.sv
hw/rtl/thermal_false_color_mapper.sv
tb/testbench.sv
